### hdl/ordered_list_table_engine_assert.svh
// Assertion macros shared by the ordered list table engine.
`ifndef ORDERED_LIST_TABLE_ENGINE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and masked during reset.
`define OLTE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ordered list table engine: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and masked during reset.
`define OLTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordered list table engine: next-cycle check failed");

`endif

### hdl/olte_pkg.sv
// Package with constants, codes and types of the ordered list table engine.
package olte_pkg;

  localparam int CAPACITY    = 64;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int VALUE_W     = 32;
  localparam int OP_W        = 3;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_HEAD_INS  = 3'd0,
    OP_TAIL_INS  = 3'd1,
    OP_ORD_INS   = 3'd2,
    OP_DROP_HEAD = 3'd3,
    OP_DROP_TAIL = 3'd4,
    OP_REMOVE    = 3'd5,
    OP_CLEAR     = 3'd6
  } olte_op_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } olte_status_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_COMMIT = 1'b1
  } olte_state_e;

  // Broadcast to every cell in the commit cycle.
  typedef struct packed {
    logic ins;
    logic del;
  } olte_ctrl_t;

endpackage

### hdl/ordered_list_table_engine.sv
// Ordered list table engine: a row of cells holding up to CAPACITY signed
// 32-bit entries in list order. A command is taken when start is high and
// busy is low. In the cycle a command is taken all cells compare the value
// at once and the hit pattern is registered; in the next cycle (busy high)
// the first hit is picked out and every cell shifts, loads or holds
// together. The result is shown on done_o, status_o and entry_count_o in
// the following cycle, which is also the earliest cycle in which the next
// command can be taken; no command is taken while busy is high.
// Results cannot be held off and must be captured when done_o is high.
module ordered_list_table_engine
  import olte_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [OP_W-1:0]               operation_i,
  input  logic signed [VALUE_W-1:0]     item_value_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [COUNT_OUT_W-1:0]        entry_count_o
);

  `include "ordered_list_table_engine_assert.svh"

  olte_state_e               state_q, state_d;
  logic                      accept;
  logic                      commit;

  logic [CNT_W-1:0]          count_q, count_d;
  olte_op_e                  op_q;
  logic signed [VALUE_W-1:0] val_q;
  logic [CAPACITY-1:0]       cand_q, cand_d;
  logic                      done_q;
  olte_status_e              status_q, status_d;

  logic signed [VALUE_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]       cell_le, cell_lt, cell_eq;
  logic [CAPACITY-1:0]       valid, cnt_oh, last_oh;
  logic [CAPACITY-1:0]       cand_dec, below, first_oh;
  olte_ctrl_t                ctrl;
  logic                      full, empty, found;

  assign accept = start && !busy;

  // Control sequence.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    commit = 1'b0;
    case (state_q)
      ST_COMMIT: begin
        busy   = 1'b1;
        commit = 1'b1;
      end
      default: begin
        busy   = 1'b0;
        commit = 1'b0;
      end
    endcase
  end

  // Position masks from the current count.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      valid[k]   = CNT_W'(k) < count_q;
      cnt_oh[k]  = count_q == CNT_W'(k);
      last_oh[k] = count_q == CNT_W'(k + 1);
    end
  end

  // Candidate positions; the lowest set bit is where the list opens or closes.
  always_comb begin
    cand_d = '0;
    case (olte_op_e'(operation_i))
      OP_HEAD_INS, OP_DROP_HEAD: cand_d[0] = 1'b1;
      OP_TAIL_INS:               cand_d = cnt_oh;
      OP_ORD_INS: begin
        // A single entry is passed only by a strictly smaller value.
        if (count_q == CNT_W'(1)) begin
          cand_d = cnt_oh;
          cand_d[0] = cell_lt[0];
        end else begin
          cand_d = (cell_le & valid) | cnt_oh;
        end
      end
      OP_DROP_TAIL:              cand_d = last_oh;
      OP_REMOVE:                 cand_d = cell_eq & valid;
      default:                   cand_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= STAT_DONE;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= commit;
      if (commit) begin
        status_q <= status_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= olte_op_e'(operation_i);
      val_q  <= item_value_i;
      cand_q <= cand_d;
    end
  end

  // First-hit selection: one borrow chain over the candidate vector.
  assign cand_dec = cand_q - {{(CAPACITY-1){1'b0}}, 1'b1};
  assign below    = cand_dec & ~cand_q;
  assign first_oh = cand_q & ~cand_dec;
  assign found    = |cand_q;
  assign full     = count_q == CNT_W'(CAPACITY);
  assign empty    = count_q == '0;

  always_comb begin
    ctrl     = '0;
    status_d = STAT_DONE;
    count_d  = count_q;
    if (commit) begin
      case (op_q)
        OP_HEAD_INS, OP_TAIL_INS, OP_ORD_INS: begin
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CNT_W'(1);
          end
        end
        OP_DROP_HEAD, OP_DROP_TAIL, OP_REMOVE: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else if (!found) begin
            status_d = STAT_NOTFOUND;
          end else begin
            ctrl.del = 1'b1;
            count_d  = count_q - CNT_W'(1);
          end
        end
        OP_CLEAR: count_d = '0;
        default:  count_d = count_q;
      endcase
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [VALUE_W-1:0] left_val, right_val;

    if (k == 0) begin : g_first
      assign left_val = val_q;
    end else begin : g_inner_l
      assign left_val = cell_val[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[k];
    end else begin : g_inner_r
      assign right_val = cell_val[k+1];
    end

    olte_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .sel_ge_i    (!below[k]),
      .sel_eq_i    (first_oh[k]),
      .key_i       (item_value_i),
      .new_val_i   (val_q),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .val_o       (cell_val[k]),
      .le_o        (cell_le[k]),
      .lt_o        (cell_lt[k]),
      .eq_o        (cell_eq[k])
    );
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = COUNT_OUT_W'(count_q);

  `OLTE_ASSERT_NEXT(a_accept_then_busy, start && !busy, busy)
  `OLTE_ASSERT_NEXT(a_busy_then_done, busy, done_o && !busy)
  `OLTE_ASSERT_NOW(a_count_bounded, 1'b1, count_q <= CNT_W'(CAPACITY))
  `OLTE_ASSERT_NOW(a_full_at_capacity, done_o && status_o == STAT_FULL,
                   count_q == CNT_W'(CAPACITY))

endmodule

### hdl/olte_cell.sv
// One cell of the list: holds one entry, compares it and shifts with its neighbors.
module olte_cell
  import olte_pkg::*;
(
  input  logic                      clk_i,
  input  olte_ctrl_t                ctrl_i,
  input  logic                      sel_ge_i,
  input  logic                      sel_eq_i,
  input  logic signed [VALUE_W-1:0] key_i,
  input  logic signed [VALUE_W-1:0] new_val_i,
  input  logic signed [VALUE_W-1:0] left_val_i,
  input  logic signed [VALUE_W-1:0] right_val_i,
  output logic signed [VALUE_W-1:0] val_o,
  output logic                      le_o,
  output logic                      lt_o,
  output logic                      eq_o
);

  logic signed [VALUE_W-1:0] val_q;
  logic signed [VALUE_W-1:0] val_d;

  assign le_o  = key_i <= val_q;
  assign lt_o  = key_i < val_q;
  assign eq_o  = key_i == val_q;
  assign val_o = val_q;

  // An insert loads the gap cell and pushes the cells above it one place up;
  // a removal pulls every cell from the gap upward one place down.
  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins && sel_eq_i) begin
      val_d = new_val_i;
    end else if (ctrl_i.ins && sel_ge_i) begin
      val_d = left_val_i;
    end else if (ctrl_i.del && sel_ge_i) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
